>>> sv/sed_pkg.sv
// Shared constants for the string escape decoder.
package sed_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned ACC_W   = 9;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned SLOTS   = 3;
  localparam int unsigned CNT_W   = 2;
  localparam int unsigned TDATA_W = 24;

  // Decoder modes.
  localparam logic [MODE_W-1:0] MODE_NORMAL = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ESC    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ESC_CR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OCT1   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_OCT2   = 3'd4;

  // Result kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Character codes.
  localparam logic [CP_W-1:0] CH_BSLASH = 21'h00005C;
  localparam logic [CP_W-1:0] CH_SQUOTE = 21'h000027;
  localparam logic [CP_W-1:0] CH_DQUOTE = 21'h000022;
  localparam logic [CP_W-1:0] CH_LF     = 21'h00000A;
  localparam logic [CP_W-1:0] CH_CR     = 21'h00000D;
  localparam logic [CP_W-1:0] CH_0      = 21'h000030;
  localparam logic [CP_W-1:0] CH_7      = 21'h000037;
  localparam logic [CP_W-1:0] CH_A      = 21'h000061;
  localparam logic [CP_W-1:0] CH_B      = 21'h000062;
  localparam logic [CP_W-1:0] CH_F      = 21'h000066;
  localparam logic [CP_W-1:0] CH_N      = 21'h00006E;
  localparam logic [CP_W-1:0] CH_R      = 21'h000072;
  localparam logic [CP_W-1:0] CH_T      = 21'h000074;
  localparam logic [CP_W-1:0] CH_V      = 21'h000076;

  // Decoded control characters.
  localparam logic [CP_W-1:0] CP_BEL = 21'd7;
  localparam logic [CP_W-1:0] CP_BS  = 21'd8;
  localparam logic [CP_W-1:0] CP_FF  = 21'd12;
  localparam logic [CP_W-1:0] CP_LF  = 21'd10;
  localparam logic [CP_W-1:0] CP_CR  = 21'd13;
  localparam logic [CP_W-1:0] CP_HT  = 21'd9;
  localparam logic [CP_W-1:0] CP_VT  = 21'd11;

endpackage

>>> sv/string_escape_decoder.sv
// String escape decoder: backslash escapes to code points, one beat per cycle at best.
//
// Input channel (in_*): one code point per beat, in_tlast marks the last code
// point of a string. Result channel (out_*): one decoded code point per beat,
// out_tuser is the kind (0 character, 1 end-of-string marker carrying 0),
// out_tlast marks the final result caused by one input beat. An input beat
// may cause zero to three results.
//
// An input beat is captured in the input register, decoded combinationally and
// loaded into the result buffer when the buffer is free, and its first result is
// shown from the head of the buffer. Throughput: one input beat per cycle while
// each beat yields at most one result and the receiver takes every result; a beat
// with more results holds the next beat back until the single output port takes
// the last result in the three-slot result buffer.
//
// Reset (rst_n low, synchronous) empties both stages and returns the decoder to
// normal text with a cleared octal value. When the receiver stalls, the result
// buffer holds, the input register takes at most one more beat, then in_tready drops.
module string_escape_decoder
  import sed_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Input channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // [20:0] code_point, [23:21] zero
  input  logic               in_tlast,   // end_of_string
  // Result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [20:0] out_code_point, [23:21] zero
  output logic               out_tuser,  // kind
  output logic               out_tlast   // last_of_run
);

  // Input register
  logic            in_vld_r;
  logic [CP_W-1:0] in_cp_r;
  logic            in_eos_r;

  // Decoder state
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;

  // Result buffer, slot 0 is the head
  logic [CP_W-1:0]  res_cp_r   [SLOTS];
  logic             res_kind_r [SLOTS];
  logic             res_last_r [SLOTS];
  logic [CNT_W-1:0] res_cnt_r;

  // Decoded results of the held beat
  logic [CP_W-1:0]  d_cp   [SLOTS];
  logic             d_kind [SLOTS];
  logic             d_last [SLOTS];
  logic [CNT_W-1:0] d_n;

  logic out_fire;
  logic buf_free;
  logic load;

  assign out_fire  = out_tvalid && out_tready;
  // Buffer is empty after this edge: load the next decoded beat.
  assign buf_free  = (res_cnt_r == '0) || ((res_cnt_r == CNT_W'(1)) && out_tready);
  assign load      = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || load;

  assign out_tvalid = (res_cnt_r != '0);
  assign out_tdata  = {(TDATA_W - CP_W)'(0), res_cp_r[0]};
  assign out_tuser  = res_kind_r[0];
  assign out_tlast  = res_last_r[0];

  // Decode one code point against the current mode.
  always_comb begin
    logic            is_oct;
    logic            do_plain;
    logic [CNT_W-1:0] n;
    logic [ACC_W-1:0] digit;
    logic [ACC_W-1:0] oct_sum;

    is_oct   = (in_cp_r inside {[CH_0:CH_7]});
    // Octal digits sit at 0x30..0x37, so the low three bits are the value.
    digit    = {{(ACC_W - 3){1'b0}}, in_cp_r[2:0]};
    oct_sum  = {acc_r[ACC_W-4:0], 3'b000} + digit;
    do_plain = 1'b0;
    n        = '0;
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    for (int i = 0; i < SLOTS; i++) begin
      d_cp[i]   = '0;
      d_kind[i] = KIND_CHAR;
      d_last[i] = 1'b0;
    end

    case (mode_r)
      MODE_ESC: begin
        mode_nxt = MODE_NORMAL;
        case (in_cp_r)
          CH_LF: ;
          CH_CR: mode_nxt = MODE_ESC_CR;
          CH_BSLASH, CH_SQUOTE, CH_DQUOTE: begin
            d_cp[n] = in_cp_r;
            n = n + CNT_W'(1);
          end
          CH_A: begin d_cp[n] = CP_BEL; n = n + CNT_W'(1); end
          CH_B: begin d_cp[n] = CP_BS;  n = n + CNT_W'(1); end
          CH_F: begin d_cp[n] = CP_FF;  n = n + CNT_W'(1); end
          CH_N: begin d_cp[n] = CP_LF;  n = n + CNT_W'(1); end
          CH_R: begin d_cp[n] = CP_CR;  n = n + CNT_W'(1); end
          CH_T: begin d_cp[n] = CP_HT;  n = n + CNT_W'(1); end
          CH_V: begin d_cp[n] = CP_VT;  n = n + CNT_W'(1); end
          default: begin
            // Octal digit opens a run; anything else drops both characters.
            if (is_oct) begin
              acc_nxt  = digit;
              mode_nxt = MODE_OCT1;
            end
          end
        endcase
      end
      MODE_ESC_CR: begin
        mode_nxt = MODE_NORMAL;
        do_plain = (in_cp_r != CH_LF);
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_oct && (mode_r == MODE_OCT1)) begin
          acc_nxt  = oct_sum;
          mode_nxt = MODE_OCT2;
        end else if (is_oct) begin
          d_cp[n]  = {{(CP_W - ACC_W){1'b0}}, oct_sum};
          n        = n + CNT_W'(1);
          acc_nxt  = '0;
          mode_nxt = MODE_NORMAL;
        end else begin
          // Flush the held value, then treat the non-digit as text.
          d_cp[n]  = {{(CP_W - ACC_W){1'b0}}, acc_r};
          n        = n + CNT_W'(1);
          acc_nxt  = '0;
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    if (do_plain) begin
      if (in_cp_r == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        mode_nxt = MODE_NORMAL;
        d_cp[n]  = in_cp_r;
        n        = n + CNT_W'(1);
      end
    end

    // End of string: flush a held octal value, drop a pending escape, add the marker.
    if (in_eos_r) begin
      if ((mode_nxt == MODE_OCT1) || (mode_nxt == MODE_OCT2)) begin
        d_cp[n] = {{(CP_W - ACC_W){1'b0}}, acc_nxt};
        n       = n + CNT_W'(1);
      end
      mode_nxt  = MODE_NORMAL;
      acc_nxt   = '0;
      d_cp[n]   = '0;
      d_kind[n] = KIND_END;
      n         = n + CNT_W'(1);
    end

    if (n != '0) begin
      d_last[n - CNT_W'(1)] = 1'b1;
    end
    d_n = n;
  end

  // Input register: hold the beat until the result buffer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_cp_r  <= in_tdata[CP_W-1:0];
      in_eos_r <= in_tlast;
    end
  end

  // Decoder state advances when a beat moves into the result buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NORMAL;
      acc_r  <= '0;
    end else if (load) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

  // Result buffer: load a decoded beat, or shift one result out per accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= '0;
    end else if (load) begin
      res_cnt_r <= d_n;
    end else if (out_fire) begin
      res_cnt_r <= res_cnt_r - CNT_W'(1);
    end
    if (load) begin
      for (int i = 0; i < SLOTS; i++) begin
        res_cp_r[i]   <= d_cp[i];
        res_kind_r[i] <= d_kind[i];
        res_last_r[i] <= d_last[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        res_cp_r[i]   <= res_cp_r[i+1];
        res_kind_r[i] <= res_kind_r[i+1];
        res_last_r[i] <= res_last_r[i+1];
      end
    end
  end

endmodule

>>> test/tb.sv
// Testbench for string_escape_decoder: directed escape cases, random strings, backpressure.
`timescale 1ns / 1ps

module tb;
  import sed_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 20;

  // One decoded result as the block should present it.
  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            kind;
    logic            last;
  } decoded_t;

  logic               clk;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;   // [20:0] code_point, [23:21] zero
  logic               in_tlast   = 1'b0; // end_of_string
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;         // [20:0] out_code_point, [23:21] zero
  logic               out_tuser;         // kind
  logic               out_tlast;         // last_of_run

  // Predictor state, mirrors the decoder's escape tracking.
  logic [MODE_W-1:0] dec_mode  = MODE_NORMAL;
  logic [ACC_W-1:0]  dec_octal = '0;
  decoded_t          run_results[$];     // results of the beat being predicted
  decoded_t          expected_chars[$];  // results still owed by the block

  int errors     = 0;
  int items_sent = 0;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int hold_req   = 0;
  int hold_ack   = 0;
  int hold_left  = 0;
  int quiet_cycles = 0;

  logic [CP_W-1:0] esc_letters [10] = '{CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V,
                                        CH_BSLASH, CH_SQUOTE, CH_DQUOTE};

  string_escape_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decode predictor
  // ---------------------------------------------------------------------------
  function automatic void emit_cp(logic [CP_W-1:0] cp, logic kind);
    run_results.push_back(decoded_t'{cp, kind, 1'b0});
  endfunction

  // Normal-text handling: a backslash opens an escape, anything else passes.
  function automatic void take_plain(logic [CP_W-1:0] cp);
    if (cp == CH_BSLASH) begin
      dec_mode = MODE_ESC;
    end else begin
      dec_mode = MODE_NORMAL;
      emit_cp(cp, KIND_CHAR);
    end
  endfunction

  function automatic void predict_decode(logic [CP_W-1:0] cp, logic eos);
    logic             is_oct;
    logic [ACC_W-1:0] digit;
    logic [ACC_W-1:0] acc_next;
    is_oct   = (cp >= CH_0) && (cp <= CH_7);
    digit    = ACC_W'(cp - CH_0);
    acc_next = (dec_octal << 3) + digit;
    run_results.delete();
    case (dec_mode)
      MODE_ESC: begin
        dec_mode = MODE_NORMAL;
        case (cp)
          CH_LF: ;
          CH_CR: dec_mode = MODE_ESC_CR;
          CH_BSLASH, CH_SQUOTE, CH_DQUOTE: emit_cp(cp, KIND_CHAR);
          CH_A: emit_cp(CP_BEL, KIND_CHAR);
          CH_B: emit_cp(CP_BS, KIND_CHAR);
          CH_F: emit_cp(CP_FF, KIND_CHAR);
          CH_N: emit_cp(CP_LF, KIND_CHAR);
          CH_R: emit_cp(CP_CR, KIND_CHAR);
          CH_T: emit_cp(CP_HT, KIND_CHAR);
          CH_V: emit_cp(CP_VT, KIND_CHAR);
          default: begin
            // unknown escapes drop both characters; octal digits open a run
            if (is_oct) begin
              dec_octal = digit;
              dec_mode  = MODE_OCT1;
            end
          end
        endcase
      end
      MODE_ESC_CR: begin
        dec_mode = MODE_NORMAL;
        if (cp != CH_LF) take_plain(cp);
      end
      MODE_OCT1, MODE_OCT2: begin
        if (is_oct && dec_mode == MODE_OCT1) begin
          dec_octal = acc_next;
          dec_mode  = MODE_OCT2;
        end else if (is_oct) begin
          emit_cp(CP_W'(acc_next), KIND_CHAR);
          dec_octal = '0;
          dec_mode  = MODE_NORMAL;
        end else begin
          // flush the held value, then treat the digit-breaker as normal text
          emit_cp(CP_W'(dec_octal), KIND_CHAR);
          dec_octal = '0;
          take_plain(cp);
        end
      end
      default: take_plain(cp);
    endcase
    if (eos) begin
      if (dec_mode == MODE_OCT1 || dec_mode == MODE_OCT2) emit_cp(CP_W'(dec_octal), KIND_CHAR);
      dec_mode  = MODE_NORMAL;
      dec_octal = '0;
      emit_cp('0, KIND_END);
    end
    if (run_results.size() > 0) run_results[run_results.size()-1].last = 1'b1;
    foreach (run_results[i]) expected_chars.push_back(run_results[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender, receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // Offer one beat, hold until accepted, predict, then maybe idle a while.
  task automatic send_cp(input logic [CP_W-1:0] cp, input logic eos);
    in_tvalid <= 1'b1;
    in_tdata  <= TDATA_W'(cp);
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    predict_decode(cp, eos);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Drop valid and pause until every owed result has come back.
  task automatic wait_drained;
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_tready <= 1'b0;
      hold_left  <= HOLD_CYCLES;
      hold_ack   <= hold_req;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every result beat with the oldest prediction.
  always @(posedge clk) begin : result_check
    decoded_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got cp=%h kind=%b last=%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata !== TDATA_W'(want.cp)) begin
          errors++;
          $display("%0t: code point mismatch: expected %h, got %h",
                   $time, TDATA_W'(want.cp), out_tdata);
        end
        if (out_tuser !== want.kind) begin
          errors++;
          $display("%0t: kind mismatch: expected %b, got %b", $time, want.kind, out_tuser);
        end
        if (out_tlast !== want.last) begin
          errors++;
          $display("%0t: last-of-run mismatch: expected %b, got %b",
                   $time, want.last, out_tlast);
        end
      end
    end
  end

  // Abort when neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, expected_chars.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers and tests
  // ---------------------------------------------------------------------------
  function automatic logic [CP_W-1:0] rand_plain();
    logic [CP_W-1:0] c;
    case ($urandom_range(3))
      0:       c = CP_W'($urandom());
      1:       c = CP_W'($urandom_range(21'h10FFFF));
      default: c = CP_W'($urandom_range(8'h7E, 8'h20));
    endcase
    if (c == CH_BSLASH) c = CH_BSLASH + 1'b1;
    return c;
  endfunction

  task automatic test_plain_extremes;
    send_cp('0, 1'b0);
    send_cp({CP_W{1'b1}}, 1'b1);
  endtask

  task automatic test_simple_escapes;
    foreach (esc_letters[i]) begin
      send_cp(CH_BSLASH, 1'b0);
      send_cp(esc_letters[i], i == 9);
    end
  endtask

  task automatic test_line_continuations;
    send_cp(CH_BSLASH, 1'b0);
    send_cp(CH_LF, 1'b0);
    send_cp(CH_BSLASH, 1'b0);
    send_cp(CH_CR, 1'b0);
    send_cp(CH_LF, 1'b0);
    // CR without LF: both dropped, the next code point is plain text
    send_cp(CH_BSLASH, 1'b0);
    send_cp(CH_CR, 1'b0);
    send_cp(CH_A, 1'b1);
  endtask

  task automatic test_octal;
    // three digits at the top of the range
    send_cp(CH_BSLASH, 1'b0);
    send_cp(CH_7, 1'b0);
    send_cp(CH_7, 1'b0);
    send_cp(CH_7, 1'b0);
    // a run cut short by a backslash that starts an unknown escape
    send_cp(CH_BSLASH, 1'b0);
    send_cp(CH_0 + 3'd5, 1'b0);
    send_cp(CH_BSLASH, 1'b0);
    send_cp(CP_W'(8'h71), 1'b1);
  endtask

  task automatic test_string_end;
    // lone trailing backslash, then a two-digit run flushed by the string end
    send_cp(CH_BSLASH, 1'b1);
    send_cp(CH_BSLASH, 1'b0);
    send_cp(CH_0 + 3'd1, 1'b0);
    send_cp(CH_0 + 3'd2, 1'b1);
  endtask

  // Hold the receiver off while the sender keeps pushing multi-result beats.
  task automatic test_backpressure;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req++;
    repeat (6) begin
      send_cp(CH_BSLASH, 1'b0);
      send_cp(CH_0 + 3'd1, 1'b0);
      send_cp(CH_0 + 3'd2, 1'b0);
      send_cp(CP_W'(8'h5A), 1'b0);
    end
    send_cp(CH_BSLASH, 1'b0);
    send_cp(CH_0 + 3'd4, 1'b1);
    wait_drained;
  endtask

  // Mostly well-formed strings with random content, some noise strings.
  task automatic test_random_strings(input int sender_idle, input int receiver_stall,
                                     input int n_items);
    logic [CP_W-1:0] str_q[$];
    int              stop_at;
    bit              noisy;
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      str_q.delete();
      noisy = ($urandom_range(99) < 20);
      repeat ($urandom_range(6, 1)) begin
        if (noisy) begin
          case ($urandom_range(5))
            0:       str_q.push_back(CH_BSLASH);
            1:       str_q.push_back(CH_CR);
            2:       str_q.push_back(CH_LF);
            3:       str_q.push_back(CP_W'(CH_0 + $urandom_range(7)));
            4:       str_q.push_back(CP_W'(CH_0 + $urandom_range(9, 8)));
            default: str_q.push_back(rand_plain());
          endcase
        end else begin
          case ($urandom_range(9))
            4: begin
              str_q.push_back(CH_BSLASH);
              str_q.push_back(esc_letters[$urandom_range(9)]);
            end
            5: begin
              str_q.push_back(CH_BSLASH);
              str_q.push_back(CH_LF);
            end
            6: begin
              str_q.push_back(CH_BSLASH);
              str_q.push_back(CH_CR);
              str_q.push_back(CH_LF);
            end
            7: begin
              str_q.push_back(CH_BSLASH);
              repeat ($urandom_range(3, 1)) str_q.push_back(CP_W'(CH_0 + $urandom_range(7)));
            end
            8: begin
              str_q.push_back(CH_BSLASH);
              str_q.push_back(CH_CR);
              str_q.push_back(rand_plain());
            end
            9: begin
              str_q.push_back(CH_BSLASH);
              str_q.push_back(CP_W'($urandom()));
            end
            default: str_q.push_back(rand_plain());
          endcase
        end
      end
      // now and then leave an escape hanging at the string end
      if ($urandom_range(9) == 0) str_q.push_back(CH_BSLASH);
      foreach (str_q[i]) send_cp(str_q[i], i == str_q.size() - 1);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_extremes;
    test_simple_escapes;
    test_line_continuations;
    test_octal;
    test_string_end;
    test_backpressure;
    test_random_strings(0, 0, 80);
    test_random_strings(76, 0, 80);
    test_random_strings(0, 76, 80);
    test_random_strings(12, 12, 80);

    wait_drained;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/sed_pkg.sv
sv/string_escape_decoder.sv
test/tb.sv
